// ----- rtl/fit_policy_block_allocator_core_macros.svh -----
// assertion macros shared by the allocator modules
// no dependencies; included by the files that check their own logic
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FPBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FPBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fpba_pkg.sv -----
// types, codes and microcode rom of the fit-policy block allocator
// no dependencies; imported by the sequencer, the datapath and the top level
package fpba_pkg;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_REQ  = 1'b1;

    // placement policy codes; the unused code behaves as first fit
    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST  = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;

    // fixed field widths of the stream items
    localparam int IDXF_W = 3;
    localparam int AMTF_W = 16;

    // microprogram step addresses
    typedef logic [1:0] t_step;
    localparam t_step STEP_IDLE = 2'd0;
    localparam t_step STEP_LOAD = 2'd1;
    localparam t_step STEP_SCAN = 2'd2;
    localparam t_step STEP_FIN  = 2'd3;

    // jump conditions
    typedef enum logic [1:0] {
        COND_ACCEPT   = 2'd0,
        COND_OUT_FREE = 2'd1,
        COND_LAST     = 2'd2
    } t_cond;

    // one control word
    typedef struct packed {
        logic  take_in;   // input side ready
        logic  scan_en;   // compare the entry read last cycle
        logic  ld_wr;     // write a loaded size and its result
        logic  al_wr;     // write back the allocation and its result
        logic  dispatch;  // taken jump goes by the command
        t_cond cond;
        t_step tgt;       // target when the condition holds
        t_step alt;       // target otherwise
    } t_ctrl;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic last;       // scan is at the final entry
        logic out_free;   // output register can take a result
    } t_stat;

    // microcode rom
    function automatic t_ctrl ucode_rom(t_step s);
        t_ctrl w;
        w = '{take_in: 1'b0, scan_en: 1'b0, ld_wr: 1'b0, al_wr: 1'b0, dispatch: 1'b0,
              cond: COND_ACCEPT, tgt: STEP_IDLE, alt: STEP_IDLE};
        unique case (s)
            STEP_IDLE: begin
                w.take_in  = 1'b1;
                w.dispatch = 1'b1;
                w.cond     = COND_ACCEPT;
                w.alt      = STEP_IDLE;
            end
            STEP_LOAD: begin
                w.ld_wr = 1'b1;
                w.cond  = COND_OUT_FREE;
                w.tgt   = STEP_IDLE;
                w.alt   = STEP_LOAD;
            end
            STEP_SCAN: begin
                w.scan_en = 1'b1;
                w.cond    = COND_LAST;
                w.tgt     = STEP_FIN;
                w.alt     = STEP_SCAN;
            end
            STEP_FIN: begin
                w.al_wr = 1'b1;
                w.cond  = COND_OUT_FREE;
                w.tgt   = STEP_IDLE;
                w.alt   = STEP_FIN;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/fpba_ram.sv -----
// generic simple dual-port ram with registered read
// no dependencies; holds the free-size table of the allocator
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/fpba_seq.sv -----
// microcode sequencer: step counter, control rom and conditional jumps
// depends on fpba_pkg and the assertion macros header
`include "fit_policy_block_allocator_core_macros.svh"

module fpba_seq
    import fpba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_cmd,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_step r_step;
    t_step n_step;
    t_ctrl w_ctrl;
    logic  w_taken;

    // control word of the current step
    assign w_ctrl = ucode_rom(r_step);
    assign o_ctrl = w_ctrl;

    // condition select
    always_comb begin
        unique case (w_ctrl.cond)
            COND_ACCEPT:   w_taken = i_in_valid;
            COND_OUT_FREE: w_taken = i_stat.out_free;
            COND_LAST:     w_taken = i_stat.last;
            default:       w_taken = 1'b0;
        endcase
    end

    // next step address
    always_comb begin
        if (!w_taken) begin
            n_step = w_ctrl.alt;
        end else if (w_ctrl.dispatch) begin
            n_step = (i_in_cmd == CMD_REQ) ? STEP_SCAN : STEP_LOAD;
        end else begin
            n_step = w_ctrl.tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // an accepted item always leaves the idle step
    `FPBA_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n,
        w_ctrl.take_in && i_in_valid, !o_ctrl.take_in, "input taken twice in a row")
    // the final scanned entry leads to the write-back step
    `FPBA_ASSERT_NXT(a_last_to_fin, i_clk, i_rst_n,
        w_ctrl.scan_en && i_stat.last, r_step == STEP_FIN, "scan did not end in write-back")

endmodule

// ----- rtl/fpba_dp.sv -----
// allocator datapath: item registers, size table, scan compare and result register
// depends on fpba_pkg, fpba_ram and the assertion macros header
`include "fit_policy_block_allocator_core_macros.svh"

module fpba_dp
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = 8,
    parameter int SIZE_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    output t_stat             o_stat,
    input  logic              i_in_valid,
    input  logic              i_in_cmd,
    input  logic [IDXF_W-1:0] i_in_bidx,
    input  logic [AMTF_W-1:0] i_in_amt,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_out_grant,
    output logic [IDXF_W-1:0] o_out_idx,
    output logic [AMTF_W-1:0] o_out_rem
);

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BLOCKS - 1);

    // item and scan registers
    logic                  r_cmd;
    logic [IDXF_W-1:0]     r_bidx;
    logic [SIZE_WIDTH-1:0] r_amt;
    logic [IW-1:0]         r_ptr;
    logic [IW-1:0]         n_ptr;
    logic                  r_found;
    logic                  n_found;
    logic [IW-1:0]         r_pick;
    logic [IW-1:0]         n_pick;
    logic [SIZE_WIDTH-1:0] r_pick_sz;
    logic [SIZE_WIDTH-1:0] n_pick_sz;
    logic [1:0]            r_policy;
    logic [NUM_BLOCKS-1:0] r_valid;
    logic                  r_rd_vld;

    // result register
    logic                  r_out_vld;
    logic                  r_out_grant;
    logic [IDXF_W-1:0]     r_out_idx;
    logic [AMTF_W-1:0]     r_out_rem;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_last;
    logic                  w_ld_go;
    logic                  w_al_go;
    logic                  w_load_ok;
    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    logic [SIZE_WIDTH-1:0] w_wdata;
    logic [IW-1:0]         w_raddr;
    logic [SIZE_WIDTH-1:0] w_rdata;
    logic [SIZE_WIDTH-1:0] w_sz;
    logic [SIZE_WIDTH-1:0] w_left;
    logic                  w_fits;
    logic                  w_better;

    assign w_accept   = i_ctrl.take_in && i_in_valid;
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_last     = (r_ptr == LAST_IDX);
    assign w_ld_go    = i_ctrl.ld_wr && w_out_free;
    assign w_al_go    = i_ctrl.al_wr && w_out_free;
    assign w_load_ok  = (32'(r_bidx) < 32'(NUM_BLOCKS));
    assign w_left     = r_pick_sz - r_amt;

    assign o_stat.last     = w_last;
    assign o_stat.out_free = w_out_free;

    // table write: a loaded size or the reduced size of the picked entry
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pick;
        w_wdata = w_left;
        if (w_ld_go && w_load_ok) begin
            w_we    = 1'b1;
            w_waddr = IW'(r_bidx);
            w_wdata = r_amt;
        end else if (w_al_go && r_found) begin
            w_we = 1'b1;
        end
    end

    // read one entry ahead of the compare
    assign w_raddr = (i_ctrl.scan_en && !w_last) ? (r_ptr + 1'b1) : '0;

    fpba_ram #(
        .WIDTH (SIZE_WIDTH),
        .DEPTH (NUM_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // entries never written read as zero
    assign w_sz   = r_rd_vld ? w_rdata : '0;
    assign w_fits = (w_sz >= r_amt);

    // policy compare against the current pick
    always_comb begin
        unique case (r_policy)
            POLICY_BEST:  w_better = (w_sz < r_pick_sz);
            POLICY_WORST: w_better = (w_sz > r_pick_sz);
            default:      w_better = 1'b0;
        endcase
    end

    // scan pointer and pick
    always_comb begin
        n_ptr     = '0;
        n_found   = r_found;
        n_pick    = r_pick;
        n_pick_sz = r_pick_sz;
        if (i_ctrl.take_in) begin
            n_found = 1'b0;
        end else if (i_ctrl.scan_en) begin
            n_ptr = w_last ? '0 : (r_ptr + 1'b1);
            if (w_fits && (!r_found || w_better)) begin
                n_found   = 1'b1;
                n_pick    = r_ptr;
                n_pick_sz = w_sz;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_found   <= 1'b0;
            r_policy  <= POLICY_FIRST;
            r_valid   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_ptr    <= n_ptr;
            r_found  <= n_found;
            r_rd_vld <= r_valid[w_raddr];
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (w_ld_go || w_al_go) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pick    <= n_pick;
        r_pick_sz <= n_pick_sz;
        if (w_accept) begin
            r_cmd  <= i_in_cmd;
            r_bidx <= i_in_bidx;
            r_amt  <= SIZE_WIDTH'(i_in_amt);
        end
        if (w_ld_go) begin
            r_out_grant <= 1'b0;
            r_out_idx   <= r_bidx;
            r_out_rem   <= w_load_ok ? AMTF_W'(r_amt) : '0;
        end else if (w_al_go) begin
            r_out_grant <= r_found;
            r_out_idx   <= r_found ? IDXF_W'(r_pick) : '0;
            r_out_rem   <= r_found ? AMTF_W'(w_left) : '0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_grant = r_out_grant;
    assign o_out_idx   = r_out_idx;
    assign o_out_rem   = r_out_rem;

    // a pick always fits the requested amount
    `FPBA_ASSERT_IMP(a_pick_fits, i_clk, i_rst_n,
        r_found && (i_ctrl.scan_en || i_ctrl.al_wr), r_pick_sz >= r_amt,
        "picked entry smaller than request")
    // once found during a scan, a fit is never lost
    `FPBA_ASSERT_NXT(a_found_sticks, i_clk, i_rst_n,
        i_ctrl.scan_en && r_found, r_found, "found flag dropped mid-scan")
    // a write-back only runs for a request
    `FPBA_ASSERT_IMP(a_fin_is_req, i_clk, i_rst_n,
        i_ctrl.al_wr, r_cmd == CMD_REQ, "write-back for a load item")

endmodule

// ----- rtl/fit_policy_block_allocator_core.sv -----
// top level of the fit-policy block allocator: stream ports, sequencer and datapath
// depends on fpba_pkg, fpba_seq, fpba_dp and fpba_ram

// Keeps a free-size table of NUM_BLOCKS entries (all zero after reset) and serves one item at a
// time. A load item (tuser 0) writes one entry and answers with that index and size; a request
// (tuser 1) picks a fitting entry under the policy register (first, best or worst fit, ties to
// the lowest index), subtracts the amount and answers with the grant, index and remaining size.
// A request steps through accepting the item, a scan of every table entry through the single
// read port of the size ram and a write-back; a load is accepted and then writes one entry.
// A result sits in an output register, so the next item is accepted while it waits; the block
// stalls only when a new result is ready and the previous one has not been taken. No clearing
// pass follows reset: per-entry valid bits make unwritten entries read as zero.
module fit_policy_block_allocator_core
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = 8,
    parameter int SIZE_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: placement policy
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [2:0] block_index, [18:3] amount, rest zero
    input  logic        s_axis_tuser,   // [0] cmd
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [2:0] chosen_block, [18:3] remaining, rest zero
    output logic        m_axis_tuser    // [0] granted
);

    t_ctrl             w_ctrl;
    t_stat             w_stat;
    logic [IDXF_W-1:0] w_out_idx;
    logic [AMTF_W-1:0] w_out_rem;

    assign s_axis_tready = w_ctrl.take_in;

    // microcode sequencer
    fpba_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    // datapath with the size table
    fpba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (s_axis_tuser),
        .i_in_bidx   (s_axis_tdata[2:0]),
        .i_in_amt    (s_axis_tdata[18:3]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_grant (m_axis_tuser),
        .o_out_idx   (w_out_idx),
        .o_out_rem   (w_out_rem)
    );

    // result packing
    assign m_axis_tdata = {5'd0, w_out_rem, w_out_idx};

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for fit_policy_block_allocator_core: random and directed loads and
// requests under every placement policy, checked against a behavioral free-size table
// depends on fpba_pkg and the rtl of the allocator
module testbench;
    import fpba_pkg::*;

    localparam int          CLK_PERIOD      = 20;
    localparam int          NUM_BLOCKS      = 8;
    localparam int          RAND_PHASES     = 10;
    localparam int          ITEMS_PER_PHASE = 165;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          DRAIN_CYCLES    = 20;
    localparam logic [1:0]  POLICY_UNUSED   = 2'd3;
    localparam logic [1:0]  POLICY_ORDER [4] =
        '{POLICY_BEST, POLICY_WORST, POLICY_UNUSED, POLICY_FIRST};

    typedef struct {
        logic              cmd;
        logic [IDXF_W-1:0] block_index;
        logic [AMTF_W-1:0] amount;
    } alloc_item_t;

    typedef struct {
        logic              granted;
        logic [IDXF_W-1:0] chosen_block;
        logic [AMTF_W-1:0] remaining;
    } alloc_result_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_wdata   = 2'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = 24'd0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    // behavioral copy of the table and the policy register
    logic [AMTF_W-1:0] free_size [NUM_BLOCKS];
    logic [1:0]        cur_policy = POLICY_FIRST;

    alloc_item_t   req_queue[$];
    alloc_result_t expected_grants[$];

    alloc_item_t tx_item = '{cmd: CMD_LOAD, block_index: '0, amount: '0};
    bit          tx_have  = 1'b0;
    bit          tx_quiet = 1'b0;
    int          tx_gap   = 0;
    bit          rx_quiet = 1'b0;
    int          rx_wait  = 0;
    int          items_in = 0;
    int          hold_left = 0;
    int          holds_done = 0;
    int          idle_cycles = 0;
    int          errors = 0;

    fit_policy_block_allocator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // apply one item to the table and return the answer the block should give
    function automatic alloc_result_t allocate_or_load(alloc_item_t it);
        alloc_result_t r;
        logic          found;
        int            pick;
        r     = '{granted: 1'b0, chosen_block: '0, remaining: '0};
        found = 1'b0;
        pick  = 0;
        if (it.cmd == CMD_LOAD) begin
            free_size[it.block_index] = it.amount;
            r.chosen_block = it.block_index;
            r.remaining    = it.amount;
        end else begin
            // first fitting entry wins unless best or worst fit finds a strictly better one
            for (int j = 0; j < NUM_BLOCKS; j++) begin
                if (free_size[j] >= it.amount) begin
                    if (!found) begin
                        found = 1'b1;
                        pick  = j;
                    end else if (cur_policy == POLICY_BEST && free_size[j] < free_size[pick]) begin
                        pick = j;
                    end else if (cur_policy == POLICY_WORST && free_size[j] > free_size[pick]) begin
                        pick = j;
                    end
                end
            end
            if (found) begin
                free_size[pick] = free_size[pick] - it.amount;
                r.granted       = 1'b1;
                r.chosen_block  = pick[IDXF_W-1:0];
                r.remaining     = free_size[pick];
            end
        end
        return r;
    endfunction

    function automatic void add_item(logic cmd, int idx, int amt);
        alloc_item_t it;
        it.cmd         = cmd;
        it.block_index = idx[IDXF_W-1:0];
        it.amount      = amt[AMTF_W-1:0];
        req_queue.push_back(it);
    endfunction

    // write the policy register; only called while nothing is in flight
    task automatic set_policy(input logic [1:0] p);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_policy = p;
    endtask

    // wait until every request is sent and every answer is back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (req_queue.size() != 0 || s_axis_tvalid || expected_grants.size() != 0);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_have = 1'b0;
            tx_gap  = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_grants.push_back(allocate_or_load(tx_item));
                items_in <= items_in + 1;
                tx_have = 1'b0;
                tx_gap  = tx_quiet ? 0 : $urandom_range(0, 12);
                if ($urandom_range(0, 31) == 0)
                    tx_quiet = !tx_quiet;
            end
            if (!tx_have) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (req_queue.size() > 0) begin
                    tx_item = req_queue.pop_front();
                    tx_have = 1'b1;
                end
            end
            s_axis_tvalid <= tx_have;
            s_axis_tdata  <= {5'd0, tx_item.amount, tx_item.block_index};
            s_axis_tuser  <= tx_item.cmd;
        end
    end

    // long receiver hold-off, twice during the random part
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left == 0 && holds_done < 2 && items_in >= (holds_done + 1) * 600) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin
        alloc_result_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_grants.size() == 0) begin
                    $error("result with no request outstanding: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    want = expected_grants.pop_front();
                    if (m_axis_tuser !== want.granted) begin
                        $error("granted: expected %0d, got %0d", want.granted, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[2:0] !== want.chosen_block) begin
                        $error("chosen_block: expected %0d, got %0d",
                               want.chosen_block, m_axis_tdata[2:0]);
                        errors++;
                    end
                    if (m_axis_tdata[18:3] !== want.remaining) begin
                        $error("remaining: expected %0d, got %0d",
                               want.remaining, m_axis_tdata[18:3]);
                        errors++;
                    end
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 12);
                if ($urandom_range(0, 31) == 0)
                    rx_quiet = !rx_quiet;
            end else if (m_axis_tvalid && rx_wait > 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[fit_policy_block_allocator_core] ERROR");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial begin
        int         ph;
        int         n;
        int         kind;
        int         sz;
        logic [1:0] p;

        foreach (free_size[k])
            free_size[k] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first fit on the cleared table, then a full load
        set_policy(POLICY_FIRST);
        add_item(CMD_REQ, 5, 0);            // zero amount fits the empty table
        add_item(CMD_REQ, 2, 1);            // nothing fits
        add_item(CMD_REQ, 7, 16'hFFFF);
        add_item(CMD_LOAD, 0, 16'hFFFF);
        add_item(CMD_LOAD, 1, 100);
        add_item(CMD_LOAD, 2, 40);
        add_item(CMD_LOAD, 3, 100);
        add_item(CMD_LOAD, 4, 16'h5555);
        add_item(CMD_LOAD, 5, 16'h2AAA);
        add_item(CMD_LOAD, 6, 40);
        add_item(CMD_LOAD, 7, 16'h8000);
        add_item(CMD_REQ, 0, 50);
        add_item(CMD_REQ, 0, 16'hFFFF);     // just misses after the subtraction
        wait_idle();

        // best fit: ties to the lowest index, exact fits leave zero
        set_policy(POLICY_BEST);
        add_item(CMD_REQ, 3, 40);
        add_item(CMD_REQ, 6, 40);
        add_item(CMD_REQ, 1, 0);
        add_item(CMD_REQ, 4, 101);
        wait_idle();

        // worst fit with a full-size block
        set_policy(POLICY_WORST);
        add_item(CMD_LOAD, 3, 16'hFFFF);
        add_item(CMD_REQ, 0, 16'hFFFF);
        add_item(CMD_REQ, 0, 1);
        wait_idle();

        // unused policy code acts as first fit
        set_policy(POLICY_UNUSED);
        add_item(CMD_REQ, 2, 100);
        add_item(CMD_REQ, 2, 0);
        wait_idle();

        // random phases: mostly small sizes on a few grid values so fits and ties are common
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            p = (ph < 4) ? POLICY_ORDER[ph] : 2'($urandom_range(0, 3));
            set_policy(p);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                kind = $urandom_range(0, 9);
                if ($urandom_range(0, 99) < 35) begin
                    case (kind)
                        0, 1, 2, 3, 4: sz = $urandom_range(0, 7) * 8;
                        5, 6:          sz = $urandom_range(0, 255);
                        7:             sz = $urandom_range(0, 16'hFFFF);
                        8:             sz = 16'hFFFF;
                        default:       sz = 0;
                    endcase
                    add_item(CMD_LOAD, $urandom_range(0, 7), sz);
                end else begin
                    case (kind)
                        0, 1, 2, 3, 4: sz = $urandom_range(0, 4) * 8;
                        5, 6:          sz = $urandom_range(0, 255);
                        7:             sz = $urandom_range(0, 16'hFFFF);
                        8:             sz = 0;
                        default:       sz = 16'hFFFF;
                    endcase
                    add_item(CMD_REQ, $urandom_range(0, 7), sz);
                end
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("[fit_policy_block_allocator_core] OK");
        else
            $display("[fit_policy_block_allocator_core] ERROR");
        $finish;
    end

endmodule
